>>> design/stlu_pkg.sv
// ----------------------------------------------------------------------------
// stlu_pkg: shared codes for the until robustness monitor
// Opcodes, mode codes, register indexes and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package stlu_pkg;

	localparam int WLEN_W = 7;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_PRIME  = 2'd1;
	localparam logic [1:0] OP_SAMPLE = 2'd2;

	localparam logic [1:0] MODE_UNBOUNDED = 2'd0;
	localparam logic [1:0] MODE_OFFSET    = 2'd1;
	localparam logic [1:0] MODE_WINDOW    = 2'd2;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_WLEN = 1'b1;

	typedef enum logic {
		S_IDLE,
		S_SWEEP
	} ctl_state_t;

endpackage

`default_nettype wire

>>> design/stlu_cell.sv
// ----------------------------------------------------------------------------
// stlu_cell: one window entry of the bounded until chain
// Holds one candidate value. When the sweep token passes, the entry is
// replaced by the new candidate or, if inside the window, tightened by
// phi1; live entries extend the running maximum handed to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module stlu_cell #(
	parameter int VALUE_BITS = 32,
	parameter int IDX        = 0,
	parameter int IDX_W      = 6,
	parameter int CNT_W      = 7
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         clear,
	input  wire logic                         tok_valid_in,
	input  wire logic signed [VALUE_BITS-1:0] max_in,
	input  wire logic        [IDX_W-1:0]      slot,
	input  wire logic        [CNT_W-1:0]      size,
	input  wire logic signed [VALUE_BITS-1:0] p1,
	input  wire logic signed [VALUE_BITS-1:0] cand,
	output logic                              tok_valid_out,
	output logic signed      [VALUE_BITS-1:0] max_out
);

	localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(IDX);
	localparam logic [CNT_W-1:0] MY_CNT  = CNT_W'(IDX);

	logic signed [VALUE_BITS-1:0] val_q;
	logic signed [VALUE_BITS-1:0] val_next;
	logic signed [VALUE_BITS-1:0] max_next;
	logic signed [VALUE_BITS-1:0] max_q;
	logic                         valid_q;
	logic                         is_slot;
	logic                         live;

	assign is_slot = (slot == MY_SLOT);
	assign live    = (MY_CNT < size);

	always_comb begin
		if (is_slot) begin
			val_next = cand;
		end else if (live) begin
			val_next = (val_q <= p1) ? val_q : p1;
		end else begin
			val_next = val_q;
		end
		if (live && (val_next > max_in)) begin
			max_next = val_next;
		end else begin
			max_next = max_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_valid_in;
			if (clear) begin
				val_q <= '0;
			end else if (tok_valid_in) begin
				val_q <= val_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		max_q <= max_next;
	end

	assign tok_valid_out = valid_q;
	assign max_out       = max_q;

endmodule

`default_nettype wire

>>> design/stl_until_robustness.sv
// ----------------------------------------------------------------------------
// stl_until_robustness: signal temporal logic until robustness monitor
// Unbounded modes use a running min/max recurrence; the bounded mode keeps
// a window of candidates in a chain of cells swept by a token.
// ----------------------------------------------------------------------------
// Results pass through a pending register and an output register; a window
// mode result is first swept through every cell of the chain by the token.
// Throughput: one item per cycle outside window mode while results drain; a
// window mode sample holds off new items while the token walks the chain.
// Reset: arst_n clears control registers, window entries and the running value at once.
`default_nettype none

module stl_until_robustness
	import stlu_pkg::*;
#(
	parameter int WIN_MAX    = 64,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic        [2:0]            paddr,
	input  wire logic        [31:0]           pwdata,
	output logic             [31:0]           prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic        [1:0]            opcode,
	input  wire logic signed [VALUE_BITS-1:0] left_value,
	input  wire logic signed [VALUE_BITS-1:0] right_value,
	input  wire logic signed [VALUE_BITS-1:0] left_window_min,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed      [VALUE_BITS-1:0] robustness
);

	localparam int IDX_W = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
	localparam int CNT_W = $clog2(WIN_MAX + 1);
	localparam int EW    = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
	localparam int SW    = EW + 1;
	localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	function automatic logic signed [VALUE_BITS-1:0] smin(
		input logic signed [VALUE_BITS-1:0] a,
		input logic signed [VALUE_BITS-1:0] b
	);
		return (a <= b) ? a : b;
	endfunction

	function automatic logic signed [VALUE_BITS-1:0] smax(
		input logic signed [VALUE_BITS-1:0] a,
		input logic signed [VALUE_BITS-1:0] b
	);
		return (a >= b) ? a : b;
	endfunction

	// Configuration registers.
	logic [1:0]        mode_q;
	logic [WLEN_W-1:0] wlen_q;
	logic              cfg_wr;

	// Control and trace state.
	ctl_state_t                   state_q;
	ctl_state_t                   state_d;
	logic signed [VALUE_BITS-1:0] running_q;
	logic                         primed_q;
	logic        [CNT_W-1:0]      fill_q;
	logic        [IDX_W-1:0]      slot_q;
	logic                         launch_q;

	// Operands broadcast to the cells during a sweep.
	logic signed [VALUE_BITS-1:0] p1_hold_q;
	logic signed [VALUE_BITS-1:0] cand_hold_q;
	logic        [IDX_W-1:0]      slot_hold_q;
	logic        [CNT_W-1:0]      size_hold_q;

	// Result buffering.
	logic signed [VALUE_BITS-1:0] pend_q;
	logic                         pend_valid_q;
	logic signed [VALUE_BITS-1:0] out_q;
	logic                         out_valid_q;

	logic                         in_acc;
	logic                         drain;
	logic                         mode_window;
	logic                         is_start;
	logic                         is_prime;
	logic                         is_sample;
	logic                         fast_sample;
	logic                         win_sample;
	logic                         sweep_done;
	logic signed [VALUE_BITS-1:0] r_fast;
	logic signed [VALUE_BITS-1:0] cand;

	logic [SW-1:0] wlen_ext;
	logic [SW-1:0] w_eff;
	logic [SW-1:0] fill_ext;
	logic [SW-1:0] fill_eff;
	logic [SW-1:0] slot_ext;
	logic [SW-1:0] slot_eff;
	logic [SW-1:0] fill_inc;
	logic [SW-1:0] size_new;
	logic [SW-1:0] slot_inc;
	logic [SW-1:0] slot_new;

	logic                         tok_v [WIN_MAX+1];
	logic signed [VALUE_BITS-1:0] tok_m [WIN_MAX+1];

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_MODE: prdata = {30'd0, mode_q};
			REG_WLEN: prdata = {{(32-WLEN_W){1'b0}}, wlen_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UNBOUNDED;
			wlen_q <= WLEN_W'(1);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MODE) begin
				mode_q <= pwdata[1:0];
			end else begin
				wlen_q <= pwdata[WLEN_W-1:0];
			end
		end
	end

	// ---------------- decode ----------------
	// The unused mode code behaves as the window mode.
	assign mode_window = (mode_q != MODE_UNBOUNDED) && (mode_q != MODE_OFFSET);
	assign in_acc      = in_valid && in_ready;
	assign is_start    = in_acc && (opcode == OP_START);
	assign is_prime    = in_acc && (opcode == OP_PRIME) && (mode_q == MODE_OFFSET);
	assign is_sample   = in_acc && (opcode == OP_SAMPLE);
	assign fast_sample = is_sample && !mode_window;
	assign win_sample  = is_sample && mode_window;
	assign sweep_done  = (state_q == S_SWEEP) && tok_v[WIN_MAX];
	assign drain       = pend_valid_q && (!out_valid_q || out_ready);

	always_comb begin
		if (mode_q == MODE_OFFSET) begin
			r_fast = smax(smin(left_window_min, right_value), smin(running_q, left_value));
		end else begin
			r_fast = smax(smin(left_value, right_value), smin(running_q, left_value));
		end
	end

	assign cand = smin(left_window_min, right_value);

	// Window geometry. A length of zero counts as one and anything above the
	// chain length is clamped; a stale fill is clamped, a stale slot reset to 0.
	always_comb begin
		wlen_ext = SW'(wlen_q);
		if (wlen_ext == '0) begin
			w_eff = SW'(1);
		end else if (wlen_ext > SW'(WIN_MAX)) begin
			w_eff = SW'(WIN_MAX);
		end else begin
			w_eff = wlen_ext;
		end
		fill_ext = SW'(fill_q);
		fill_eff = (fill_ext > w_eff) ? w_eff : fill_ext;
		slot_ext = SW'(slot_q);
		slot_eff = (slot_ext >= w_eff) ? '0 : slot_ext;
		fill_inc = fill_eff + SW'(1);
		size_new = (fill_inc > w_eff) ? w_eff : fill_inc;
		slot_inc = slot_eff + SW'(1);
		slot_new = (slot_inc == w_eff) ? '0 : slot_inc;
	end

	// ---------------- control ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (win_sample) begin
					state_d = S_SWEEP;
				end
			end
			S_SWEEP: begin
				if (tok_v[WIN_MAX]) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_IDLE:  in_ready = !pend_valid_q || drain;
			S_SWEEP: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			running_q    <= VAL_MIN;
			primed_q     <= 1'b0;
			fill_q       <= '0;
			slot_q       <= '0;
			launch_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= win_sample;

			if (is_start) begin
				running_q <= VAL_MIN;
				primed_q  <= 1'b0;
				fill_q    <= '0;
				slot_q    <= '0;
			end else if (is_prime) begin
				running_q <= primed_q ? smin(running_q, left_value) : left_value;
				primed_q  <= 1'b1;
			end else if (fast_sample) begin
				running_q <= r_fast;
			end else if (win_sample) begin
				fill_q <= CNT_W'(size_new);
				slot_q <= IDX_W'(slot_new);
			end else if (sweep_done) begin
				running_q <= tok_m[WIN_MAX];
			end

			if (fast_sample || sweep_done) begin
				pend_valid_q <= 1'b1;
			end else if (drain) begin
				pend_valid_q <= 1'b0;
			end

			if (drain) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (win_sample) begin
			p1_hold_q   <= left_value;
			cand_hold_q <= cand;
			slot_hold_q <= IDX_W'(slot_eff);
			size_hold_q <= CNT_W'(size_new);
		end
		if (fast_sample) begin
			pend_q <= r_fast;
		end else if (sweep_done) begin
			pend_q <= tok_m[WIN_MAX];
		end
		if (drain) begin
			out_q <= pend_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign robustness = out_q;

	// ---------------- cell chain ----------------
	assign tok_v[0] = launch_q;
	assign tok_m[0] = VAL_MIN;

	for (genvar k = 0; k < WIN_MAX; k++) begin : g_cell
		stlu_cell #(
			.VALUE_BITS (VALUE_BITS),
			.IDX        (k),
			.IDX_W      (IDX_W),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.clear         (is_start),
			.tok_valid_in  (tok_v[k]),
			.max_in        (tok_m[k]),
			.slot          (slot_hold_q),
			.size          (size_hold_q),
			.p1            (p1_hold_q),
			.cand          (cand_hold_q),
			.tok_valid_out (tok_v[k+1]),
			.max_out       (tok_m[k+1])
		);
	end

endmodule

`default_nettype wire

>>> design/stlu_checker.sv
// ----------------------------------------------------------------------------
// stlu_checker: port-level checks for the until robustness monitor
// Tracks sample transactions against result transactions and checks the
// output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module stlu_checker
	import stlu_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic        [1:0]            opcode,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic signed [VALUE_BITS-1:0] robustness
);

	logic [1:0] cnt_q;
	logic       smp_acc;
	logic       res_acc;

	assign smp_acc = in_valid && in_ready && (opcode == OP_SAMPLE);
	assign res_acc = out_valid && out_ready;

	// Samples accepted whose result transaction has not completed yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (smp_acc && !res_acc) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (res_acc && !smp_acc) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(robustness))
		else $error("result changed or dropped while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 2'd0)
		else $error("result shown with no sample outstanding");

	a_buffer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("more samples outstanding than the block can buffer");

endmodule

bind stl_until_robustness stlu_checker #(.VALUE_BITS(VALUE_BITS)) u_stlu_checker (.*);

`default_nettype wire

>>> tb/sv/stl_until_robustness_test.sv
// ----------------------------------------------------------------------------
// stl_until_robustness_test: self-checking bench for the until robustness monitor
// Streams traces through the three until modes under changing register values,
// predicts each robustness result in the bench and compares it with the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stl_until_robustness_test;
	import stlu_pkg::*;

	localparam int WIN_MAX      = 64;
	localparam int RANDOM_ITEMS = 1150;
	localparam int SETTLE       = WIN_MAX + 8;
	localparam int LIMIT        = 1000000;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [2:0] ADDR_MODE  = {REG_MODE, 2'b00};
	localparam logic [2:0] ADDR_WLEN  = {REG_WLEN, 2'b00};

	typedef logic signed [31:0] fix_t;
	localparam fix_t FIX_MAX = 32'sh7fff_ffff;
	localparam fix_t FIX_MIN = 32'sh8000_0000;

	typedef struct {
		logic [1:0] op;
		fix_t       lv;
		fix_t       rv;
		fix_t       wm;
	} until_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;
	logic        in_valid = 1'b0;
	wire         in_ready;
	logic [1:0]  opcode = OP_START;
	fix_t        left_value = '0;
	fix_t        right_value = '0;
	fix_t        left_window_min = '0;
	wire         out_valid;
	logic        out_ready = 1'b0;
	wire  [31:0] robustness;

	stl_until_robustness #(
		.WIN_MAX(WIN_MAX),
		.VALUE_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.left_value(left_value),
		.right_value(right_value),
		.left_window_min(left_window_min),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.robustness(robustness)
	);

	// Bench copy of the block's registers and trace state.
	logic [1:0] mode_q = MODE_UNBOUNDED;
	logic [6:0] wlen_q = 7'd1;
	fix_t       run_val_q = FIX_MIN;
	fix_t       cells_q [WIN_MAX];
	int         fill_q = 0;
	int         slot_q = 0;
	bit         primed_q = 1'b0;

	until_item_t item_backlog [$];
	fix_t        robustness_due [$];

	bit in_accepted = 1'b0;
	int send_idle_pct = 6;
	int recv_idle_pct = 86;
	int error_count = 0;
	int results_checked = 0;
	int config_writes = 0;
	int samples_by_mode [4] = '{0, 0, 0, 0};
	int items_made = 0;
	int cycle_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic fix_t fix_min(fix_t a, fix_t b);
		return (a <= b) ? a : b;
	endfunction

	function automatic fix_t fix_max(fix_t a, fix_t b);
		return (a >= b) ? a : b;
	endfunction

	function automatic int eff_window(logic [6:0] w);
		if (w < 1)
			return 1;
		if (w > WIN_MAX)
			return WIN_MAX;
		return int'(w);
	endfunction

	function automatic fix_t rand_value();
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return FIX_MAX;
		if (pick == 1)
			return FIX_MIN;
		if (pick == 2)
			return '0;
		if (pick == 3)
			return -1;
		if (pick < 10)
			return fix_t'($urandom_range(0, 32)) - 16;
		return fix_t'($urandom());
	endfunction

	task automatic clear_trace();
		run_val_q = FIX_MIN;
		foreach (cells_q[i])
			cells_q[i] = '0;
		fill_q = 0;
		slot_q = 0;
		primed_q = 1'b0;
	endtask

	// Updates the trace state for one accepted transaction and predicts a sample's result.
	task automatic predict_until(logic [1:0] op, fix_t lv, fix_t rv, fix_t wm);
		fix_t r;
		int   w;
		int   size;
		int   k;
		if (op == OP_START) begin
			clear_trace();
			return;
		end
		if (op == OP_PRIME) begin
			if (mode_q == MODE_OFFSET) begin
				run_val_q = primed_q ? fix_min(run_val_q, lv) : lv;
				primed_q = 1'b1;
			end
			return;
		end
		if (op != OP_SAMPLE)
			return;
		samples_by_mode[mode_q]++;
		if (mode_q == MODE_UNBOUNDED) begin
			r = fix_max(fix_min(lv, rv), fix_min(run_val_q, lv));
		end else if (mode_q == MODE_OFFSET) begin
			r = fix_max(fix_min(wm, rv), fix_min(run_val_q, lv));
		end else begin
			w = eff_window(wlen_q);
			if (fill_q > w)
				fill_q = w;
			if (slot_q >= w)
				slot_q = 0;
			r = fix_min(wm, rv);
			cells_q[slot_q] = r;
			size = (fill_q + 1 > w) ? w : fill_q + 1;
			fill_q = size;
			for (int j = 1; j < size; j++) begin
				k = (slot_q + j) % size;
				cells_q[k] = fix_min(cells_q[k], lv);
				r = fix_max(r, cells_q[k]);
			end
			slot_q = (slot_q + 1) % w;
		end
		run_val_q = r;
		robustness_due.push_back(r);
	endtask

	// Monitor: checks results and feeds accepted transactions to the predictor.
	always @(posedge clk) begin : monitor
		fix_t due_r;
		in_accepted = 1'b0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (robustness_due.size() == 0) begin
					$error("unexpected result: robustness %0d", $signed(robustness));
					error_count++;
				end else begin
					due_r = robustness_due.pop_front();
					results_checked++;
					if (robustness !== due_r) begin
						$error("robustness mismatch: expected %0d, actual %0d",
							due_r, $signed(robustness));
						error_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				in_accepted = 1'b1;
				predict_until(opcode, left_value, right_value, left_window_min);
			end
		end
	end

	// Driver: presents the next pending item unless the current one is still waiting.
	always @(negedge clk) begin : driver
		until_item_t nxt;
		if (!in_valid || in_accepted) begin
			if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = item_backlog.pop_front();
				opcode <= nxt.op;
				left_value <= nxt.lv;
				right_value <= nxt.rv;
				left_window_min <= nxt.wm;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (arst_n)
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	task automatic push_item(logic [1:0] op, fix_t lv, fix_t rv, fix_t wm);
		until_item_t it;
		it.op = op;
		it.lv = lv;
		it.rv = rv;
		it.wm = wm;
		item_backlog.push_back(it);
		items_made++;
	endtask

	task automatic push_rand(logic [1:0] op);
		push_item(op, rand_value(), rand_value(), rand_value());
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (addr == ADDR_MODE)
			mode_q = data[1:0];
		else
			wlen_q = data[6:0];
		config_writes++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		while (item_backlog.size() != 0 || in_valid || robustness_due.size() != 0)
			@(posedge clk);
	endtask

	// Window entries are only defined once written, so a longer window that could
	// expose unwritten entries is always followed by a start of trace.
	task automatic set_config(logic [1:0] mode, logic [6:0] wlen, output bit grew);
		grew = eff_window(wlen) > eff_window(wlen_q);
		apb_write(ADDR_MODE, {30'd0, mode});
		apb_write(ADDR_WLEN, {25'd0, wlen});
	endtask

	task automatic queue_trace(logic [1:0] mode, bit lead, int n);
		int unsigned roll;
		if (lead) begin
			push_rand(OP_START);
			if (mode == MODE_OFFSET)
				repeat ($urandom_range(0, 4)) push_rand(OP_PRIME);
		end
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < 4)
				push_rand(OP_UNUSED);
			else if (roll < 9)
				push_rand(OP_PRIME);
			else if (roll < 11)
				push_rand(OP_START);
			else
				push_rand(OP_SAMPLE);
		end
	endtask

	initial begin : stimulus
		bit          grew;
		bit          lead;
		logic [1:0]  mode;
		logic [6:0]  wlen;
		int unsigned pick;
		int          n;
		int          phase_no;
		int          progress;
		int          directed_made;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: unbounded mode, extremes and ignored opcodes.
		push_item(OP_SAMPLE, FIX_MAX, FIX_MIN, '0);
		push_item(OP_SAMPLE, FIX_MAX, FIX_MAX, '0);
		push_item(OP_SAMPLE, FIX_MIN, FIX_MAX, FIX_MIN);
		push_item(OP_PRIME, 5, 0, 0);
		push_item(OP_UNUSED, FIX_MIN, FIX_MAX, FIX_MIN);
		push_item(OP_SAMPLE, -1, '0, FIX_MAX);
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		// Offset mode, first sampled before any prime, then primed.
		set_config(MODE_OFFSET, 7'd1, grew);
		push_item(OP_START, '0, '0, '0);
		push_item(OP_SAMPLE, 7, 3, -2);
		push_item(OP_PRIME, FIX_MAX, '0, '0);
		push_item(OP_PRIME, 9, '0, '0);
		push_item(OP_SAMPLE, 20, FIX_MAX, FIX_MIN);
		push_item(OP_SAMPLE, FIX_MIN, FIX_MIN, FIX_MAX);
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		// Window mode with a zero length, which acts as a single entry.
		set_config(MODE_WINDOW, 7'd0, grew);
		push_rand(OP_START);
		push_rand(OP_SAMPLE);
		push_rand(OP_PRIME);
		push_rand(OP_SAMPLE);
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		set_config(MODE_WINDOW, 7'd3, grew);
		push_rand(OP_START);
		repeat (4) push_rand(OP_SAMPLE);
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		// Spare mode code with an over-long window.
		set_config(MODE_SPARE, 7'd127, grew);
		push_rand(OP_START);
		repeat (3) push_rand(OP_SAMPLE);
		directed_made = items_made;

		phase_no = 0;
		while (items_made < directed_made + RANDOM_ITEMS) begin
			wait_drained();
			repeat (SETTLE) @(posedge clk);
			progress = items_made - directed_made;
			if (progress < RANDOM_ITEMS / 3) begin
				send_idle_pct = 6;
				recv_idle_pct = 86;
			end else if (progress < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 86;
				recv_idle_pct = 6;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			mode = 2'($urandom_range(0, 3));
			pick = $urandom_range(0, 9);
			if (pick == 0)
				wlen = 7'd0;
			else if (pick == 1)
				wlen = 7'd1;
			else if (pick == 2)
				wlen = 7'(WIN_MAX);
			else if (pick == 3)
				wlen = 7'($urandom_range(WIN_MAX + 1, 127));
			else
				wlen = 7'($urandom_range(2, 8));
			set_config(mode, wlen, grew);
			lead = grew || ($urandom_range(0, 9) < 7);
			n = $urandom_range(8, 40);
			if (phase_no % 7 == 3) begin
				// Hold the sender off mid-trace until every result is back.
				queue_trace(mode, lead, n / 2);
				wait_drained();
				queue_trace(mode, 1'b0, n - n / 2);
			end else begin
				queue_trace(mode, lead, n);
			end
			phase_no++;
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		$display("Checked %0d results across %0d register writes and %0d traces.",
			results_checked, config_writes, phase_no + 5);
		$display("Samples by mode code 0/1/2/3: %0d/%0d/%0d/%0d.", samples_by_mode[0],
			samples_by_mode[1], samples_by_mode[2], samples_by_mode[3]);
		if (error_count == 0 && robustness_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
